FILE: rtl/core/msvu_pkg.sv
// ----------------------------------------------------------------------------
// msvu_pkg
// Shared types, constants and saturation helpers for the mass-spring unit
// ----------------------------------------------------------------------------
package msvu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int ACC_BITS  = WORD_BITS + 16;
   localparam int REG_BITS  = 31;
   localparam int PROD_BITS = 2 * WORD_BITS;

   localparam int SQRT_STEPS    = PROD_BITS / 2;
   localparam int SQRT_CNT_BITS = $clog2(SQRT_STEPS + 1);
   localparam int DIV_STEPS     = PROD_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DAMPING   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAVITY   = 2'd2;

   localparam logic [REG_BITS-1:0] TIME_STEP_RESET = 31'd33;
   localparam logic [REG_BITS-1:0] DAMPING_RESET   = 31'd0;
   localparam logic [REG_BITS-1:0] GRAVITY_RESET   = 31'd642908;
   localparam logic [REG_BITS-1:0] MASS_RESET      = 31'd65536;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_EDGE   = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam logic signed [63:0] WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] WORD_MIN = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] ACC_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] ACC_MIN  = 64'shFFFF_8000_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_H_MUL,
      ST_H_ACC,
      ST_G_MUL,
      ST_G_ACC,
      ST_E_DIFF,
      ST_E_SQ_MUL,
      ST_E_SQ_ACC,
      ST_E_SQRT_GO,
      ST_E_SQRT_WAIT,
      ST_E_EXT,
      ST_E_T_MUL,
      ST_E_DIV_GO,
      ST_E_DIV_WAIT,
      ST_E_K_MUL,
      ST_E_K_ACC,
      ST_FIN,
      ST_O_MUL,
      ST_O_DIV_GO,
      ST_O_DIV_WAIT,
      ST_O_PUSH
   } msvu_state_type;

   typedef struct packed {
      logic                   start;
      logic [PROD_BITS-1:0]   dividend;
      logic [WORD_BITS-1:0]   divisor;
   } msvu_div_req_type;

   typedef struct packed {
      logic                   done;
      logic [PROD_BITS-1:0]   quotient;
   } msvu_div_rsp_type;

   typedef struct packed {
      logic                 ovf;
      logic [WORD_BITS-1:0] val;
   } msvu_word_sat_type;

   typedef struct packed {
      logic                ovf;
      logic [ACC_BITS-1:0] val;
   } msvu_acc_sat_type;

   function automatic logic [WORD_BITS-1:0] mag32(input logic signed [WORD_BITS-1:0] v);
      mag32 = v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
   endfunction

   function automatic msvu_word_sat_type sat_word(input logic signed [63:0] v);
      msvu_word_sat_type r;
      r.ovf = 1'b0;
      r.val = v[WORD_BITS-1:0];
      if (v > WORD_MAX) begin
         r.ovf = 1'b1;
         r.val = WORD_MAX[WORD_BITS-1:0];
      end else if (v < WORD_MIN) begin
         r.ovf = 1'b1;
         r.val = WORD_MIN[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic msvu_acc_sat_type sat_acc(input logic signed [63:0] v);
      msvu_acc_sat_type r;
      r.ovf = 1'b0;
      r.val = v[ACC_BITS-1:0];
      if (v > ACC_MAX) begin
         r.ovf = 1'b1;
         r.val = ACC_MAX[ACC_BITS-1:0];
      end else if (v < ACC_MIN) begin
         r.ovf = 1'b1;
         r.val = ACC_MIN[ACC_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/msvu_if.sv
// ----------------------------------------------------------------------------
// msvu_if
// Valid/ready channels of the mass-spring unit: items, results, register writes
// ----------------------------------------------------------------------------
interface msvu_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic [30:0]        weight;
   logic [30:0]        rest_length;
   logic               last;
   modport source (output valid, opcode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   weight, rest_length, last, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 weight, rest_length, last, output ready);
endinterface

interface msvu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic signed [31:0] force_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic [1:0]         status;
   modport source (output valid, force_x, force_y, force_z, new_vel_x, new_vel_y,
                   new_vel_z, status, input ready);
   modport sink (input valid, force_x, force_y, force_z, new_vel_x, new_vel_y,
                 new_vel_z, status, output ready);
endinterface

interface msvu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [30:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/msvu_mul.sv
// ----------------------------------------------------------------------------
// msvu_mul
// Shared 32 x 32 unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module msvu_mul (
   input  logic                          clock,
   input  logic [msvu_pkg::WORD_BITS-1:0] mul_a,
   input  logic [msvu_pkg::WORD_BITS-1:0] mul_b,
   output logic [msvu_pkg::PROD_BITS-1:0] product
);
   import msvu_pkg::*;

   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;

   assign prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

FILE: rtl/core/msvu_sqrt.sv
// ----------------------------------------------------------------------------
// msvu_sqrt
// Iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module msvu_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [msvu_pkg::PROD_BITS-1:0] radicand,
   output logic                          done,
   output logic [msvu_pkg::WORD_BITS-1:0] root
);
   import msvu_pkg::*;

   logic [PROD_BITS-1:0]     rad_ff, rad_in;
   logic [WORD_BITS+2:0]     rem_ff, rem_in;
   logic [WORD_BITS-1:0]     root_ff, root_in;
   logic [SQRT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [WORD_BITS+2:0]     rem_sh;
   logic [WORD_BITS+2:0]     trial;
   logic                     fits;

   assign rem_sh = {rem_ff[WORD_BITS:0], rad_ff[PROD_BITS-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SQRT_CNT_BITS'(SQRT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[PROD_BITS-3:0], 2'b00};
         rem_in  = fits ? rem_sh - trial : rem_sh;
         root_in = {root_ff[WORD_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == SQRT_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: rtl/core/msvu_div.sv
// ----------------------------------------------------------------------------
// msvu_div
// Iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module msvu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  msvu_pkg::msvu_div_req_type  div_req,
   output msvu_pkg::msvu_div_rsp_type  div_rsp
);
   import msvu_pkg::*;

   logic [PROD_BITS-1:0]    num_ff, num_in;
   logic [WORD_BITS-1:0]    rem_ff, rem_in;
   logic [WORD_BITS-1:0]    den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [WORD_BITS:0]      rem_sh;
   logic [WORD_BITS:0]      rem_sub;
   logic                    fits;

   assign rem_sh  = {rem_ff, num_ff[PROD_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[PROD_BITS-2:0], fits};
         rem_in = fits ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

FILE: rtl/core/mass_spring_velocity_update.sv
// ----------------------------------------------------------------------------
// mass_spring_velocity_update
// Force accumulation and velocity update for one mass-spring node
// ----------------------------------------------------------------------------
// Usage: a node is a header transaction on req_ch (opcode 0: position,
// velocity, mass) followed by spring-edge transactions (opcode 1: neighbour
// position, stiffness, rest length). The transaction with last set produces one
// result on rsp_ch: total force, new velocity and a status code.
// Registers are to be written on csr_ch (always ready) only while the unit is
// idle; the unit itself does not enforce this. One item is taken at a time;
// req_ch.ready is low while it is worked on. An edge runs one 32-step square
// root and, unless the length is zero, three 64-step divisions by the spring
// length. The last item adds three 64-step divisions by the mass.
// req_ch.ready returns in the cycle after ST_FIN, or after the push for a last item.
// Multiplies share one registered 32x32 multiplier.
// The result sits in an output register, so the unit goes on with the next
// item; a later result waits in the final state until that register is taken.
// Reset (synchronous) restores register defaults, clears node state to zero
// and mass to one, and clears error flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mass_spring_velocity_update (
   input  logic       clock,
   input  logic       reset,
   msvu_req_if.sink   req_ch,
   msvu_rsp_if.source rsp_ch,
   msvu_csr_if.sink   csr_ch
);
   import msvu_pkg::*;

   msvu_state_type state_ff, state_in;
   logic [1:0]     ax_ff, ax_in;

   logic [REG_BITS-1:0] dt_ff, dt_in, damp_ff, damp_in, grav_ff, grav_in;

   logic signed [WORD_BITS-1:0] pos_ff [3];
   logic signed [WORD_BITS-1:0] pos_in [3];
   logic signed [WORD_BITS-1:0] vel_ff [3];
   logic signed [WORD_BITS-1:0] vel_in [3];
   logic signed [ACC_BITS-1:0]  fsum_ff [3];
   logic signed [ACC_BITS-1:0]  fsum_in [3];
   logic [REG_BITS-1:0]         mass_ff, mass_in;
   logic [1:0]                  err_ff, err_in;

   logic signed [WORD_BITS-1:0] it_pos_ff [3];
   logic signed [WORD_BITS-1:0] it_pos_in [3];
   logic [REG_BITS-1:0]         it_wt_ff, it_wt_in, it_rl_ff, it_rl_in;
   logic                        it_last_ff, it_last_in;

   logic signed [WORD_BITS-1:0] d_ff [3];
   logic signed [WORD_BITS-1:0] d_in [3];
   logic [PROD_BITS-1:0]        sumsq_ff, sumsq_in;
   logic [WORD_BITS-1:0]        len_ff, len_in, ue_ff, ue_in, t_ff, t_in;
   logic                        extneg_ff, extneg_in;

   logic signed [WORD_BITS-1:0] fo_ff [3];
   logic signed [WORD_BITS-1:0] fo_in [3];
   logic signed [WORD_BITS-1:0] vo_ff [3];
   logic signed [WORD_BITS-1:0] vo_in [3];
   logic [1:0]                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [WORD_BITS-1:0] mul_a, mul_b;
   logic [PROD_BITS-1:0] product;
   logic                 sq_start, sq_done;
   logic [WORD_BITS-1:0] sq_root;
   msvu_div_req_type     div_req;
   msvu_div_rsp_type     div_rsp;

   logic req_fire, push, out_free;

   msvu_word_sat_type         wsat, fsat;
   msvu_word_sat_type         dsat [3];
   msvu_acc_sat_type          asat;
   logic signed [ACC_BITS-1:0] damp_val;
   logic signed [63:0]        ext;
   logic signed [63:0]        contrib;
   logic signed [63:0]        dv;

   msvu_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   msvu_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sumsq_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   msvu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign push         = (state_ff == ST_O_PUSH) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_ch.opcode == OP_HEADER) ? ST_H_MUL : ST_E_DIFF;
            end
         end
         ST_H_MUL:       state_in = ST_H_ACC;
         ST_H_ACC:       state_in = (ax_ff == 2'd2) ? ST_G_MUL : ST_H_MUL;
         ST_G_MUL:       state_in = ST_G_ACC;
         ST_G_ACC:       state_in = ST_FIN;
         ST_E_DIFF:      state_in = ST_E_SQ_MUL;
         ST_E_SQ_MUL:    state_in = ST_E_SQ_ACC;
         ST_E_SQ_ACC:    state_in = (ax_ff == 2'd2) ? ST_E_SQRT_GO : ST_E_SQ_MUL;
         ST_E_SQRT_GO:   state_in = ST_E_SQRT_WAIT;
         ST_E_SQRT_WAIT: state_in = sq_done ? ST_E_EXT : ST_E_SQRT_WAIT;
         ST_E_EXT:       state_in = (len_ff == '0) ? ST_FIN : ST_E_T_MUL;
         ST_E_T_MUL:     state_in = ST_E_DIV_GO;
         ST_E_DIV_GO:    state_in = ST_E_DIV_WAIT;
         ST_E_DIV_WAIT:  state_in = div_rsp.done ? ST_E_K_MUL : ST_E_DIV_WAIT;
         ST_E_K_MUL:     state_in = ST_E_K_ACC;
         ST_E_K_ACC:     state_in = (ax_ff == 2'd2) ? ST_FIN : ST_E_T_MUL;
         ST_FIN:         state_in = it_last_ff ? ST_O_MUL : ST_IDLE;
         ST_O_MUL:       state_in = ST_O_DIV_GO;
         ST_O_DIV_GO:    state_in = ST_O_DIV_WAIT;
         ST_O_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (ax_ff == 2'd2) ? ST_O_PUSH : ST_O_MUL;
            end
         end
         ST_O_PUSH:      state_in = out_free ? ST_IDLE : ST_O_PUSH;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      ax_in      = ax_ff;
      dt_in      = dt_ff;
      damp_in    = damp_ff;
      grav_in    = grav_ff;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      fsum_in    = fsum_ff;
      mass_in    = mass_ff;
      err_in     = err_ff;
      it_pos_in  = it_pos_ff;
      it_wt_in   = it_wt_ff;
      it_rl_in   = it_rl_ff;
      it_last_in = it_last_ff;
      d_in       = d_ff;
      sumsq_in   = sumsq_ff;
      len_in     = len_ff;
      ue_in      = ue_ff;
      t_in       = t_ff;
      extneg_in  = extneg_ff;
      fo_in      = fo_ff;
      vo_in      = vo_ff;
      status_in  = status_ff;
      mul_a      = '0;
      mul_b      = '0;
      sq_start   = 1'b0;
      div_req    = '0;

      wsat     = sat_word(64'(fsum_ff[ax_ff]));
      damp_val = vel_ff[ax_ff][WORD_BITS-1] ? $signed(product[PROD_BITS-1:FRAC_BITS])
                                           : -$signed(product[PROD_BITS-1:FRAC_BITS]);
      ext      = $signed({32'd0, len_ff}) - $signed({33'd0, it_rl_ff});
      contrib  = 64'(product[PROD_BITS-1:FRAC_BITS]);
      if (d_ff[ax_ff][WORD_BITS-1] == extneg_ff) begin
         contrib = -contrib;
      end
      asat = sat_acc(64'(fsum_ff[ax_ff]) + contrib);
      dv   = $signed(div_rsp.quotient);
      if (fo_ff[ax_ff][WORD_BITS-1]) begin
         dv = -dv;
      end
      fsat = sat_word(64'(vel_ff[ax_ff]) + dv);
      for (int i = 0; i < 3; i++) begin
         dsat[i] = sat_word(64'(pos_ff[i]) - 64'(it_pos_ff[i]));
      end

      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_TIME_STEP: dt_in   = csr_ch.data;
            CSR_DAMPING:   damp_in = csr_ch.data;
            CSR_GRAVITY:   grav_in = csr_ch.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               it_pos_in[0] = req_ch.pos_x;
               it_pos_in[1] = req_ch.pos_y;
               it_pos_in[2] = req_ch.pos_z;
               it_wt_in     = req_ch.weight;
               it_rl_in     = req_ch.rest_length;
               it_last_in   = req_ch.last;
               ax_in        = 2'd0;
               if (req_ch.opcode == OP_HEADER) begin
                  pos_in[0] = req_ch.pos_x;
                  pos_in[1] = req_ch.pos_y;
                  pos_in[2] = req_ch.pos_z;
                  vel_in[0] = req_ch.vel_x;
                  vel_in[1] = req_ch.vel_y;
                  vel_in[2] = req_ch.vel_z;
                  mass_in   = (req_ch.weight == '0) ? REG_BITS'(1) : req_ch.weight;
                  err_in    = 2'b00;
               end
            end
         end
         ST_H_MUL: begin
            mul_a = WORD_BITS'(damp_ff);
            mul_b = mag32(vel_ff[ax_ff]);
         end
         ST_H_ACC: begin
            fsum_in[ax_ff] = damp_val;
            if (ax_ff != 2'd2) begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_G_MUL: begin
            mul_a = WORD_BITS'(mass_ff);
            mul_b = WORD_BITS'(grav_ff);
         end
         ST_G_ACC: begin
            asat       = sat_acc(64'(fsum_ff[2]) - 64'(product[PROD_BITS-1:FRAC_BITS]));
            fsum_in[2] = asat.val;
            err_in[1]  = err_ff[1] | asat.ovf;
         end
         ST_E_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               d_in[i] = dsat[i].val;
            end
            err_in[1] = err_ff[1] | dsat[0].ovf | dsat[1].ovf | dsat[2].ovf;
            sumsq_in  = '0;
            ax_in     = 2'd0;
         end
         ST_E_SQ_MUL: begin
            mul_a = mag32(d_ff[ax_ff]);
            mul_b = mag32(d_ff[ax_ff]);
         end
         ST_E_SQ_ACC: begin
            sumsq_in = sumsq_ff + product;
            if (ax_ff != 2'd2) begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_E_SQRT_GO: begin
            sq_start = 1'b1;
         end
         ST_E_SQRT_WAIT: begin
            if (sq_done) begin
               len_in = sq_root;
            end
         end
         ST_E_EXT: begin
            ax_in     = 2'd0;
            extneg_in = ext[63];
            ue_in     = ext[63] ? WORD_BITS'(-ext) : WORD_BITS'(ext);
            if (len_ff == '0) begin
               err_in[0] = 1'b1;
            end
         end
         ST_E_T_MUL: begin
            mul_a = mag32(d_ff[ax_ff]);
            mul_b = ue_ff;
         end
         ST_E_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = product;
            div_req.divisor  = len_ff;
         end
         ST_E_DIV_WAIT: begin
            if (div_rsp.done) begin
               t_in = div_rsp.quotient[WORD_BITS-1:0];
            end
         end
         ST_E_K_MUL: begin
            mul_a = WORD_BITS'(it_wt_ff);
            mul_b = t_ff;
         end
         ST_E_K_ACC: begin
            fsum_in[ax_ff] = asat.val;
            err_in[1]      = err_ff[1] | asat.ovf;
            if (ax_ff != 2'd2) begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_FIN: begin
            ax_in = 2'd0;
         end
         ST_O_MUL: begin
            fo_in[ax_ff] = wsat.val;
            err_in[1]    = err_ff[1] | wsat.ovf;
            mul_a        = mag32($signed(wsat.val));
            mul_b        = WORD_BITS'(dt_ff);
         end
         ST_O_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = product;
            div_req.divisor  = WORD_BITS'(mass_ff);
         end
         ST_O_DIV_WAIT: begin
            if (div_rsp.done) begin
               vo_in[ax_ff] = fsat.val;
               err_in[1]    = err_ff[1] | fsat.ovf;
               if (ax_ff != 2'd2) begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end
         ST_O_PUSH: begin
            if (err_ff[1]) begin
               status_in = STATUS_SAT;
            end else if (err_ff[0]) begin
               status_in = STATUS_ZERO;
            end else begin
               status_in = STATUS_OK;
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      it_pos_ff  <= it_pos_in;
      it_wt_ff   <= it_wt_in;
      it_rl_ff   <= it_rl_in;
      it_last_ff <= it_last_in;
      d_ff       <= d_in;
      sumsq_ff   <= sumsq_in;
      len_ff     <= len_in;
      ue_ff      <= ue_in;
      t_ff       <= t_in;
      extneg_ff  <= extneg_in;
      fo_ff      <= fo_in;
      vo_ff      <= vo_in;
      if (push) begin
         status_ff <= status_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= 2'd0;
         dt_ff        <= TIME_STEP_RESET;
         damp_ff      <= DAMPING_RESET;
         grav_ff      <= GRAVITY_RESET;
         pos_ff       <= '{default: '0};
         vel_ff       <= '{default: '0};
         fsum_ff      <= '{default: '0};
         mass_ff      <= MASS_RESET;
         err_ff       <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         dt_ff        <= dt_in;
         damp_ff      <= damp_in;
         grav_ff      <= grav_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         fsum_ff      <= fsum_in;
         mass_ff      <= mass_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register, loaded only when the output side is free
   logic signed [WORD_BITS-1:0] ro_f_ff [3];
   logic signed [WORD_BITS-1:0] ro_v_ff [3];

   always_ff @(posedge clock) begin
      if (push) begin
         ro_f_ff <= fo_ff;
         ro_v_ff <= vo_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.force_x   = ro_f_ff[0];
   assign rsp_ch.force_y   = ro_f_ff[1];
   assign rsp_ch.force_z   = ro_f_ff[2];
   assign rsp_ch.new_vel_x = ro_v_ff[0];
   assign rsp_ch.new_vel_y = ro_v_ff[1];
   assign rsp_ch.new_vel_z = ro_v_ff[2];
   assign rsp_ch.status    = status_ff;

   // checks
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_E_DIV_WAIT || state_ff == ST_O_DIV_WAIT))
      else $error("divider finished outside a division wait");

   a_sqrt_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_E_SQRT_WAIT))
      else $error("square root finished outside its wait");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      ax_ff != 2'd3)
      else $error("axis counter out of range");

   a_push_sets_valid: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not presented after push");

endmodule
